[design/nsf_pkg.sv]
// Package: shared types, character codes and helpers for the NMEA sentence framer.
package nsf_pkg;

  localparam int MAX_BODY_DEF = 82;
  localparam int LEN_W        = 7;
  localparam int BYTE_W       = 8;
  localparam int OUT_TDATA_W  = 24;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_BODY    = 3'd1,
    PH_HEX_HI  = 3'd2,
    PH_HEX_LO  = 3'd3,
    PH_WANT_CR = 3'd4,
    PH_WANT_LF = 3'd5
  } phase_t;

  typedef struct packed {
    logic             checksum_checked;
    logic [LEN_W-1:0] frame_length;
    logic             frame_drop;
    logic             frame_good;
    logic             body_valid;
    logic [7:0]       body_byte;
  } nsf_result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.ok    = 1'b1;
      h.value = 4'(c - CH_0);
    end else if (c >= CH_A && c <= CH_F) begin
      h.ok    = 1'b1;
      h.value = 4'(c - CH_A + 8'd10);
    end
    return h;
  endfunction

endpackage

[design/nsf_core.sv]
// Sentence state machine: frame state registers and the per-byte update.
module nsf_core import nsf_pkg::*; #(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  logic [7:0]  rx_byte,
  output nsf_result_t result
);

  localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MAX_BODY);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             had_cs_r, had_cs_nxt;
  hex_t             hx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      xor_r    <= 8'd0;
      hi_r     <= 4'd0;
      count_r  <= '0;
      had_cs_r <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      xor_r    <= xor_nxt;
      hi_r     <= hi_nxt;
      count_r  <= count_nxt;
      had_cs_r <= had_cs_nxt;
    end
  end

  always_comb begin
    hx         = hex_decode(rx_byte);
    phase_nxt  = phase_r;
    xor_nxt    = xor_r;
    hi_nxt     = hi_r;
    count_nxt  = count_r;
    had_cs_nxt = had_cs_r;
    result     = '0;
    unique case (phase_r)
      PH_BODY: begin
        if (rx_byte == CH_STAR) begin
          had_cs_nxt = 1'b1;
          phase_nxt  = PH_HEX_HI;
        end else if (rx_byte == CH_CR) begin
          phase_nxt = PH_WANT_LF;
        end else if (count_r >= MAX_CNT) begin
          result.frame_drop = 1'b1;
          phase_nxt  = PH_HUNT;
          xor_nxt    = 8'd0;
          hi_nxt     = 4'd0;
          count_nxt  = '0;
          had_cs_nxt = 1'b0;
        end else begin
          result.body_byte  = rx_byte;
          result.body_valid = 1'b1;
          xor_nxt   = xor_r ^ rx_byte;
          count_nxt = count_r + LEN_W'(1);
        end
      end
      PH_HEX_HI: begin
        if (hx.ok) begin
          hi_nxt    = hx.value;
          phase_nxt = PH_HEX_LO;
        end else begin
          result.frame_drop = 1'b1;
          phase_nxt  = PH_HUNT;
          xor_nxt    = 8'd0;
          hi_nxt     = 4'd0;
          count_nxt  = '0;
          had_cs_nxt = 1'b0;
        end
      end
      PH_HEX_LO: begin
        if (hx.ok && {hi_r, hx.value} == xor_r) begin
          phase_nxt = PH_WANT_CR;
        end else begin
          result.frame_drop = 1'b1;
          phase_nxt  = PH_HUNT;
          xor_nxt    = 8'd0;
          hi_nxt     = 4'd0;
          count_nxt  = '0;
          had_cs_nxt = 1'b0;
        end
      end
      PH_WANT_CR: begin
        if (rx_byte == CH_CR) begin
          phase_nxt = PH_WANT_LF;
        end else begin
          result.frame_drop = 1'b1;
          phase_nxt  = PH_HUNT;
          xor_nxt    = 8'd0;
          hi_nxt     = 4'd0;
          count_nxt  = '0;
          had_cs_nxt = 1'b0;
        end
      end
      PH_WANT_LF: begin
        if (rx_byte == CH_LF) begin
          result.frame_good       = 1'b1;
          result.frame_length     = count_r;
          result.checksum_checked = had_cs_r;
        end else begin
          result.frame_drop = 1'b1;
        end
        phase_nxt  = PH_HUNT;
        xor_nxt    = 8'd0;
        hi_nxt     = 4'd0;
        count_nxt  = '0;
        had_cs_nxt = 1'b0;
      end
      default: begin
        phase_nxt  = (rx_byte == CH_START) ? PH_BODY : PH_HUNT;
        xor_nxt    = 8'd0;
        hi_nxt     = 4'd0;
        count_nxt  = '0;
        had_cs_nxt = 1'b0;
      end
    endcase
  end

endmodule

[design/nmea_sentence_framer.sv]
// Top level: NMEA 0183 sentence framer with input and result registers.
//
// Usage:
//   in_*  : one received serial byte per transaction (in_tdata[7:0]).
//   out_* : exactly one result per input byte, in order. Each result carries
//           the body byte when it belongs to a sentence body, a good-frame
//           flag with body length and checksum status on the closing LF,
//           or a drop flag when a sentence is abandoned.
//   Data path: an accepted byte is captured in the input register, decoded
//   combinationally from it, and loaded into the result register once that
//   register is empty or its result is being taken.
//   Throughput: one byte per cycle while out_tready is high; the state
//   update is a single short step between the input and result registers.
//   Reset: rst_n low clears both register valids and returns the framer to
//   hunting for '$' with zero checksum and count.
//   Stall: while out_tready is low the result register holds; one more byte
//   is taken into the input register, then in_tready drops until the result
//   is taken.
module nmea_sentence_framer import nsf_pkg::*; #(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] body_byte, [8] body_valid, [9] frame_good, [10] frame_drop,
  // [17:11] frame_length, [18] checksum_checked, [23:19] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int RES_W = $bits(nsf_result_t);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  nsf_result_t out_res_r;
  nsf_result_t res;
  logic        step;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
    if (step) out_res_r <= res;
  end

  nsf_core #(
    .MAX_BODY (MAX_BODY)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step),
    .rx_byte (in_byte_r),
    .result  (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_r};

  a_good_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res_r.frame_good && out_res_r.frame_drop))
    else $error("frame_good and frame_drop together");

  a_body_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.body_valid |-> !out_res_r.frame_good && !out_res_r.frame_drop)
    else $error("body byte flagged as frame end");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.frame_good |-> out_res_r.frame_length <= LEN_W'(MAX_BODY))
    else $error("frame length beyond maximum body");

  a_checked_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res_r.checksum_checked |-> out_res_r.frame_good)
    else $error("checksum_checked without frame_good");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |=> in_valid_r && $stable(in_byte_r))
    else $error("input register lost a byte during stall");

endmodule

[tb/nsf_checker.sv]
`timescale 1ns / 100ps
// Checker: predicts each framer result from the accepted input bytes and compares it.
module nsf_checker import nsf_pkg::*; #(
  parameter int MAX_BODY = MAX_BODY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     errors,
  output int                     pending
);

  localparam int RES_W = $bits(nsf_result_t);

  phase_t           phase;
  logic [7:0]       xor_acc;
  logic [3:0]       hi_nibble;
  logic [LEN_W-1:0] body_cnt;
  logic             had_sum;

  nsf_result_t result_q[$];
  nsf_result_t want;
  nsf_result_t head;
  nsf_result_t got;
  logic [7:0]  rx;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic        restart;
  int          mismatches = 0;
  int          n_results  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      phase     = PH_HUNT;
      xor_acc   = '0;
      hi_nibble = '0;
      body_cnt  = '0;
      had_sum   = 1'b0;
      result_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        rx      = in_tdata;
        want    = '0;
        restart = 1'b0;
        is_hex  = 1'b0;
        hex_val = '0;
        if (rx >= CH_0 && rx <= CH_9) begin
          is_hex  = 1'b1;
          hex_val = rx[3:0];
        end else if (rx >= CH_A && rx <= CH_F) begin
          is_hex  = 1'b1;
          hex_val = rx[3:0] + 4'd9;
        end
        case (phase)
          PH_BODY: begin
            if (rx == CH_STAR) begin
              had_sum = 1'b1;
              phase   = PH_HEX_HI;
            end else if (rx == CH_CR) begin
              phase = PH_WANT_LF;
            end else if (body_cnt >= MAX_BODY) begin
              want.frame_drop = 1'b1;
              restart         = 1'b1;
            end else begin
              want.body_byte  = rx;
              want.body_valid = 1'b1;
              xor_acc         = xor_acc ^ rx;
              body_cnt        = body_cnt + 1'b1;
            end
          end
          PH_HEX_HI: begin
            if (is_hex) begin
              hi_nibble = hex_val;
              phase     = PH_HEX_LO;
            end else begin
              want.frame_drop = 1'b1;
              restart         = 1'b1;
            end
          end
          PH_HEX_LO: begin
            if (is_hex && {hi_nibble, hex_val} == xor_acc) begin
              phase = PH_WANT_CR;
            end else begin
              want.frame_drop = 1'b1;
              restart         = 1'b1;
            end
          end
          PH_WANT_CR: begin
            if (rx == CH_CR) begin
              phase = PH_WANT_LF;
            end else begin
              want.frame_drop = 1'b1;
              restart         = 1'b1;
            end
          end
          PH_WANT_LF: begin
            if (rx == CH_LF) begin
              want.frame_good       = 1'b1;
              want.frame_length     = body_cnt;
              want.checksum_checked = had_sum;
            end else begin
              want.frame_drop = 1'b1;
            end
            restart = 1'b1;
          end
          default: begin
            if (rx == CH_START) phase = PH_BODY;
          end
        endcase
        if (restart) begin
          phase     = PH_HUNT;
          xor_acc   = '0;
          hi_nibble = '0;
          body_cnt  = '0;
          had_sum   = 1'b0;
        end
        result_q.push_back(want);
      end

      if (out_tvalid && out_tready) begin
        got = out_tdata[RES_W-1:0];
        if (result_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("result %0d: unexpected transaction, data %h", n_results, out_tdata);
          end
          mismatches++;
        end else begin
          head = result_q.pop_front();
          if (got.body_byte !== head.body_byte || got.body_valid !== head.body_valid ||
              got.frame_good !== head.frame_good || got.frame_drop !== head.frame_drop ||
              got.frame_length !== head.frame_length ||
              got.checksum_checked !== head.checksum_checked ||
              out_tdata[OUT_TDATA_W-1:RES_W] !== '0) begin
            if (mismatches < 10) begin
              $display("result %0d: expected byte=%h bv=%b good=%b drop=%b len=%0d chk=%b",
                       n_results, head.body_byte, head.body_valid, head.frame_good,
                       head.frame_drop, head.frame_length, head.checksum_checked);
              $display("result %0d: actual   byte=%h bv=%b good=%b drop=%b len=%0d chk=%b pad=%h",
                       n_results, got.body_byte, got.body_valid, got.frame_good,
                       got.frame_drop, got.frame_length, got.checksum_checked,
                       out_tdata[OUT_TDATA_W-1:RES_W]);
            end
            mismatches++;
          end
        end
        n_results++;
      end
    end
    errors  <= mismatches;
    pending <= result_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench top: drives NMEA byte streams into the sentence framer and gives the verdict.
module tb;
  import nsf_pkg::*;

  localparam int MAX_BODY = MAX_BODY_DEF;
  localparam int N_ITEMS  = 950;

  typedef enum int {
    FR_GOOD_SUM,
    FR_GOOD_BARE,
    FR_BAD_SUM,
    FR_BAD_HEX,
    FR_NO_CR,
    FR_NO_LF,
    FR_OVERFLOW
  } frame_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = 8'h00;  // [7:0] rx_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] body_byte, [8] body_valid, [9] frame_good, [10] frame_drop,
  // [17:11] frame_length, [18] checksum_checked, [23:19] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  int errors;
  int pending;
  int n_items  = 0;
  int n_noise  = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_hold  = 0;
  int rx_wait;

  nmea_sentence_framer #(.MAX_BODY(MAX_BODY)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  nsf_checker #(.MAX_BODY(MAX_BODY)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stall the result side for a random count after some transactions, none in quiet mode
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_wait = rx_quiet ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 14) : 0);
        if (rx_wait != 0) begin
          out_tready <= 1'b0;
          rx_hold    <= rx_wait;
        end
      end
    end else if (rx_hold <= 1) begin
      out_tready <= 1'b1;
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_0 + n : CH_A + n - 8'd10;
  endfunction

  function automatic logic [7:0] rand_byte_not(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == a || b == c);
    return b;
  endfunction

  function automatic logic [7:0] bad_hex();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = 8'h2F;
      1: b = 8'h3A;
      2: b = 8'h40;
      3: b = 8'h47;
      4: b = "a";
      5: b = "f";
      default: begin
        do b = 8'($urandom_range(0, 255));
        while ((b >= CH_0 && b <= CH_9) || (b >= CH_A && b <= CH_F));
      end
    endcase
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 14) : 0);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    int         len;
    int         r;
    logic [7:0] sum;
    logic [7:0] b;
    r = $urandom_range(0, 15);
    if (kind == FR_OVERFLOW) len = MAX_BODY + $urandom_range(1, 3);
    else if (r == 0)         len = MAX_BODY;
    else if (r < 3)          len = $urandom_range(13, MAX_BODY);
    else                     len = $urandom_range(0, 12);
    sum = '0;
    send_byte(CH_START);
    repeat (len) begin
      b   = rand_byte_not(CH_STAR, CH_CR);
      sum = sum ^ b;
      send_byte(b);
    end
    case (kind)
      FR_GOOD_SUM: begin
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0]));
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      FR_BAD_SUM: begin
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0] ^ 4'($urandom_range(1, 15))));
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      FR_BAD_HEX: begin
        send_byte(CH_STAR);
        if ($urandom_range(0, 1)) send_byte(hex_char(sum[7:4]));
        send_byte(bad_hex());
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      FR_NO_CR: begin
        send_byte(CH_STAR);
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0]));
        send_byte(rand_byte_not(CH_CR, CH_CR));
      end
      FR_NO_LF: begin
        if ($urandom_range(0, 1)) begin
          send_byte(CH_STAR);
          send_byte(hex_char(sum[7:4]));
          send_byte(hex_char(sum[3:0]));
        end
        send_byte(CH_CR);
        send_byte(rand_byte_not(CH_LF, CH_LF));
      end
      default: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int roll;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_START); send_byte(CH_CR); send_byte(CH_LF);
    send_byte(CH_START); send_byte(CH_STAR); send_byte(CH_0); send_byte(CH_0);
    send_byte(CH_CR); send_byte(CH_LF);
    send_byte(CH_START); send_byte(CH_A); send_byte(CH_START); send_byte(CH_STAR);
    send_byte("6"); send_byte("5"); send_byte(CH_CR); send_byte(CH_LF);
    send_byte(CH_START); send_byte(CH_STAR); send_byte(CH_0); send_byte("a");
    send_byte(CH_START); send_byte(CH_CR); send_byte("X");
    drain();

    while (n_items - n_noise < N_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      roll     = $urandom_range(0, 99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)));
          n_noise++;
        end
      end
      else if (roll < 35) send_frame(FR_GOOD_SUM);
      else if (roll < 50) send_frame(FR_GOOD_BARE);
      else if (roll < 61) send_frame(FR_BAD_SUM);
      else if (roll < 72) send_frame(FR_BAD_HEX);
      else if (roll < 81) send_frame(FR_NO_CR);
      else if (roll < 91) send_frame(FR_NO_LF);
      else if (roll < 95) send_frame(FR_OVERFLOW);
      else                send_frame(FR_GOOD_SUM);
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
